// ----- rtl/core/cls_pkg.sv -----
// ----------------------------------------------------------------------------
// cls_pkg: shared types and constants of the loop-current scaler
// Item structs, configuration register indexes and the divider cell type.
// ----------------------------------------------------------------------------
package cls_pkg;

    localparam int unsigned METHANE_SCALE = 100;
    localparam int unsigned CUR_W         = 15;
    localparam int unsigned QUO_W         = 16;
    localparam int unsigned REM_W         = 48;
    localparam int unsigned SPAN_W        = 32;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_CURRENT      = 3'd0,
        REG_MAX_CURRENT      = 3'd1,
        REG_FAULT_CURRENT    = 3'd2,
        REG_METHANE_LOW_PPM  = 3'd3,
        REG_METHANE_HIGH_PPM = 3'd4,
        REG_PRESSURE_LOW_PA  = 3'd5,
        REG_PRESSURE_HIGH_PA = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] methane_value;
        logic               methane_ok;
        logic signed [31:0] pressure_value;
        logic               pressure_ok;
    } t_in_item;

    typedef struct packed {
        logic               channel;
        logic [CUR_W-1:0]   loop_ua;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [CUR_W-1:0]   min_current;
        logic [CUR_W-1:0]   max_current;
        logic [CUR_W-1:0]   fault_current;
        logic [19:0]        methane_low_ppm;
        logic [19:0]        methane_high_ppm;
        logic signed [31:0] pressure_low_pa;
        logic signed [31:0] pressure_high_pa;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic               ch;
        logic               bypass;
        logic [CUR_W-1:0]   bval;
        logic               neg;
        logic [REM_W-1:0]   rem;
        logic [SPAN_W-1:0]  span;
        logic [QUO_W-1:0]   q;
    } t_cell;

endpackage

// ----- rtl/core/current_loop_scaler.sv -----
// ----------------------------------------------------------------------------
// current_loop_scaler: two-channel range to loop-current scaler
// Turns each methane/pressure sample into two loop-current results.
// ----------------------------------------------------------------------------
// Each accepted sample yields two transactions on the output, methane then
// pressure. A sample occupies the feeder for one job per channel; a new one
// can be taken while the pressure job of the last is issued. From the feeder
// to the output register it passes stage 1, the range check and multiplier,
// stage 3 and a row of 16 one-bit divider cells. A stall on the output
// freezes the whole pipeline; one sample waits in the feeder meanwhile.
module current_loop_scaler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  cls_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output cls_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cls_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cls_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef struct packed {
        logic               valid;
        logic               ch;
        logic               ok;
        logic signed [33:0] span;
        logic signed [33:0] offs;
    } t_s1;

    typedef struct packed {
        logic                              valid;
        logic                              ch;
        logic                              bypass;
        logic [cls_pkg::CUR_W-1:0]         bval;
        logic signed [48:0]                prod;
        logic [cls_pkg::SPAN_W-1:0]        half;
        logic [cls_pkg::SPAN_W-1:0]        span;
    } t_s2;

    cls_pkg::t_cfg cfg;

    cls_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    logic en;
    logic in_acc;

    cls_pkg::t_in_item r_hold;
    logic              r_hold_v;
    logic              r_phase;

    assign en         = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_hold_v && !(en && r_phase);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_phase  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_hold_v <= 1'b1;
                r_phase  <= 1'b0;
            end else if (en && r_hold_v) begin
                r_phase  <= !r_phase;
                r_hold_v <= !r_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hold <= i_in_data;
        end
    end

    // Stage 1: pick the channel, form span and offset
    logic signed [33:0] val_s, low_s, high_s;
    logic [33:0]        m_low, m_high;
    t_s1                r_s1, n_s1;

    always_comb begin
        m_low  = 34'(cfg.methane_low_ppm) * 34'(cls_pkg::METHANE_SCALE);
        m_high = 34'(cfg.methane_high_ppm) * 34'(cls_pkg::METHANE_SCALE);
        if (r_phase) begin
            val_s  = 34'(r_hold.pressure_value);
            low_s  = 34'(cfg.pressure_low_pa);
            high_s = 34'(cfg.pressure_high_pa);
        end else begin
            val_s  = 34'(r_hold.methane_value);
            low_s  = $signed(m_low);
            high_s = $signed(m_high);
        end
        n_s1.valid = r_hold_v;
        n_s1.ch    = r_phase;
        n_s1.ok    = r_phase ? r_hold.pressure_ok : r_hold.methane_ok;
        n_s1.span  = high_s - low_s;
        n_s1.offs  = val_s - low_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (en) begin
            r_s1 <= n_s1;
        end
    end

    // Stage 2: range check and multiply
    logic signed [15:0] d;
    logic signed [33:0] sp, of;
    t_s2                r_s2, n_s2;

    always_comb begin
        sp = $signed(r_s1.span);
        of = $signed(r_s1.offs);
        d  = $signed({1'b0, cfg.max_current}) - $signed({1'b0, cfg.min_current});
        n_s2.valid  = r_s1.valid;
        n_s2.ch     = r_s1.ch;
        n_s2.bypass = 1'b1;
        n_s2.bval   = cfg.fault_current;
        n_s2.prod   = $signed({1'b0, r_s1.offs[31:0]}) * 49'(d);
        n_s2.half   = r_s1.span[32:1];
        n_s2.span   = r_s1.span[31:0];
        priority if (!r_s1.ok || sp <= 34'sd0) begin
            n_s2.bval = cfg.fault_current;
        end else if (of <= 34'sd0) begin
            n_s2.bval = cfg.min_current;
        end else if (of >= sp) begin
            n_s2.bval = cfg.max_current;
        end else begin
            n_s2.bypass = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else if (en) begin
            r_s2 <= n_s2;
        end
    end

    // Stage 3: add rounding term, split sign and magnitude
    logic signed [48:0] num;
    logic [48:0]        mag;
    cls_pkg::t_cell     r_s3, n_s3;

    always_comb begin
        num = r_s2.prod + $signed({17'd0, r_s2.half});
        mag = num[48] ? 49'(-num) : 49'(num);
        n_s3.valid  = r_s2.valid;
        n_s3.ch     = r_s2.ch;
        n_s3.bypass = r_s2.bypass;
        n_s3.bval   = r_s2.bval;
        n_s3.neg    = num[48];
        n_s3.rem    = mag[47:0];
        n_s3.span   = r_s2.span;
        n_s3.q      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else if (en) begin
            r_s3 <= n_s3;
        end
    end

    // Divider: row of one-bit cells, most significant quotient bit first
    cls_pkg::t_cell chain [cls_pkg::QUO_W+1];
    assign chain[0] = r_s3;

    for (genvar g = 0; g < cls_pkg::QUO_W; g++) begin : g_cell
        cls_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (4'(cls_pkg::QUO_W - 1 - g)),
            .i_cell  (chain[g]),
            .o_cell  (chain[g+1])
        );
    end

    // Output register: apply sign and add minimum current
    cls_pkg::t_cell     fin;
    logic signed [16:0] qs;
    logic [16:0]        sum;
    cls_pkg::t_out_item r_out, n_out;
    logic               r_out_v;

    always_comb begin
        fin = chain[cls_pkg::QUO_W];
        qs  = fin.neg ? -$signed({1'b0, fin.q}) : $signed({1'b0, fin.q});
        sum = 17'({2'b0, cfg.min_current}) + 17'(qs);
        n_out.channel = fin.ch;
        n_out.last    = fin.ch;
        n_out.loop_ua = fin.bypass ? fin.bval : sum[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= fin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    a_acc_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_hold_v) |-> (en && r_phase))
        else $error("sample accepted over an unfinished one");

    a_phase_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_hold_v)
        else $error("pressure phase without a held sample");

    a_last_is_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last == o_out_data.channel))
        else $error("last flag does not match channel");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin.valid && !fin.bypass) |-> !fin.q[cls_pkg::QUO_W-1])
        else $error("quotient exceeds current range");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_hold_v && !r_phase) |=> (r_hold_v && r_phase))
        else $error("methane job not followed by pressure job");

endmodule

// ----- rtl/core/cls_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cls_cfg_regs: configuration register file
// Holds the current limits and the two measurement ranges.
// ----------------------------------------------------------------------------
module cls_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cls_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cls_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output cls_pkg::t_cfg                    o_cfg
);

    cls_pkg::t_cfg r_cfg;
    cls_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (cls_pkg::t_reg_idx'(i_cfg_index))
                cls_pkg::REG_MIN_CURRENT:      n_cfg.min_current      = i_cfg_data[14:0];
                cls_pkg::REG_MAX_CURRENT:      n_cfg.max_current      = i_cfg_data[14:0];
                cls_pkg::REG_FAULT_CURRENT:    n_cfg.fault_current    = i_cfg_data[14:0];
                cls_pkg::REG_METHANE_LOW_PPM:  n_cfg.methane_low_ppm  = i_cfg_data[19:0];
                cls_pkg::REG_METHANE_HIGH_PPM: n_cfg.methane_high_ppm = i_cfg_data[19:0];
                cls_pkg::REG_PRESSURE_LOW_PA:  n_cfg.pressure_low_pa  = i_cfg_data;
                cls_pkg::REG_PRESSURE_HIGH_PA: n_cfg.pressure_high_pa = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_current      <= 15'd4000;
            r_cfg.max_current      <= 15'd20000;
            r_cfg.fault_current    <= 15'd3600;
            r_cfg.methane_low_ppm  <= 20'd0;
            r_cfg.methane_high_ppm <= 20'd10000;
            r_cfg.pressure_low_pa  <= 32'sd0;
            r_cfg.pressure_high_pa <= 32'sd200000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/core/cls_div_cell.sv -----
// ----------------------------------------------------------------------------
// cls_div_cell: one restoring division step
// Tries the divisor shifted by a fixed amount and retires one quotient bit.
// ----------------------------------------------------------------------------
module cls_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [3:0]        i_shift,
    input  cls_pkg::t_cell    i_cell,
    output cls_pkg::t_cell    o_cell
);

    cls_pkg::t_cell r_cell;
    cls_pkg::t_cell n_cell;
    logic [cls_pkg::REM_W-1:0] div_sh;
    logic                      take;

    always_comb begin
        div_sh = cls_pkg::REM_W'(i_cell.span) << i_shift;
        take   = i_cell.rem >= div_sh;
        n_cell = i_cell;
        if (take) begin
            n_cell.rem = i_cell.rem - div_sh;
        end
        n_cell.q = {i_cell.q[cls_pkg::QUO_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule
